### design/assert_macros.svh
// Assertion macros shared by the RTL files.
// They expect the clock i_clk and the active-low reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define MEXP_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

`define MEXP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define MEXP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

    localparam int WORD_BITS_DEF = 32;

    localparam int STEP_BITS = 4;
    localparam int PROG_LEN  = 12;

    localparam logic [0:0] REG_POWER   = 1'b0;
    localparam logic [0:0] REG_MODULUS = 1'b1;

    // Jump conditions of the control word.
    localparam logic [2:0] C_NEXT     = 3'd0;
    localparam logic [2:0] C_JUMP     = 3'd1;
    localparam logic [2:0] C_NO_INPUT = 3'd2;
    localparam logic [2:0] C_MM_BUSY  = 3'd3;
    localparam logic [2:0] C_EXP_ZERO = 3'd4;
    localparam logic [2:0] C_EXP_EVEN = 3'd5;
    localparam logic [2:0] C_OUT_BUSY = 3'd6;

    // Multiplicand source of the modular multiplier; the multiplier is always the square.
    localparam logic [1:0] SRC_ONE = 2'd0;
    localparam logic [1:0] SRC_ACC = 2'd1;
    localparam logic [1:0] SRC_SQ  = 2'd2;

    // Step labels.
    localparam logic [STEP_BITS-1:0] S_IDLE        = 4'd0;
    localparam logic [STEP_BITS-1:0] S_REDUCE_WAIT = 4'd2;
    localparam logic [STEP_BITS-1:0] S_TEST        = 4'd3;
    localparam logic [STEP_BITS-1:0] S_MUL_WAIT    = 4'd6;
    localparam logic [STEP_BITS-1:0] S_SQUARE      = 4'd7;
    localparam logic [STEP_BITS-1:0] S_SQUARE_WAIT = 4'd8;
    localparam logic [STEP_BITS-1:0] S_EMIT        = 4'd10;

    typedef struct packed {
        logic       mm_start;
        logic [1:0] mm_src;
        logic       wr_sq;
        logic       wr_acc;
        logic       shift_exp;
        logic       load;
        logic       emit;
    } t_ctl;

    typedef struct packed {
        logic [2:0]           cond;
        logic [STEP_BITS-1:0] target;
        t_ctl                 ops;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic mm_done;
        logic exp_zero;
        logic exp_even;
        logic out_busy;
    } t_status;

    localparam t_ctl OP_NONE = '{1'b0, SRC_ONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

    localparam t_uword PROGRAM [PROG_LEN] = '{
        '{C_NO_INPUT, S_IDLE,        '{1'b0, SRC_ONE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{C_NEXT,     S_IDLE,        '{1'b1, SRC_ONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{C_MM_BUSY,  S_REDUCE_WAIT, '{1'b0, SRC_ONE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{C_EXP_ZERO, S_EMIT,        OP_NONE},
        '{C_EXP_EVEN, S_SQUARE,      OP_NONE},
        '{C_NEXT,     S_IDLE,        '{1'b1, SRC_ACC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{C_MM_BUSY,  S_MUL_WAIT,    '{1'b0, SRC_ONE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{C_NEXT,     S_IDLE,        '{1'b1, SRC_SQ,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{C_MM_BUSY,  S_SQUARE_WAIT, '{1'b0, SRC_ONE, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{C_JUMP,     S_TEST,        OP_NONE},
        '{C_OUT_BUSY, S_EMIT,        '{1'b0, SRC_ONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{C_JUMP,     S_IDLE,        OP_NONE}
    };

endpackage

`default_nettype wire

### design/modular_exponentiation_core.sv
`default_nettype none
`include "assert_macros.svh"

// Modular exponentiation core: each item on the slave stream carries a base; the master
// stream returns base raised to the configured power, reduced modulo the configured modulus.
// A power of zero returns 1. A modulus of zero acts as 2^WORD_BITS.
// Power (index 0) and modulus (index 1) are written through the always-ready cfg channel.
// Writes must be made only while no item is in flight; the core does not enforce this.
// A microcoded sequencer steps a shift-add modular multiplier that handles one multiplier
// bit per cycle.
// One item is worked on at a time; the next is accepted once the result has moved to the
// output register, so a result may wait there while the following item is computed.
// If the receiver stalls and the output register is still full, the sequencer waits at its
// emit step until the result is taken.
// Reset returns power to 0 and modulus to 1 and empties the core and its output register.

module modular_exponentiation_core #(
    parameter int  WORD_BITS  = mexp_pkg::WORD_BITS_DEF,
    localparam int TDATA_BITS = ((WORD_BITS + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [TDATA_BITS-1:0] s_axis_tdata,  // base_value
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [TDATA_BITS-1:0]      m_axis_tdata,  // result_value
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [0:0]            i_cfg_index,
    input  wire logic [WORD_BITS-1:0]  i_cfg_data
);

    import mexp_pkg::*;

    logic [WORD_BITS-1:0] r_power;
    logic [WORD_BITS-1:0] r_mod;
    logic [WORD_BITS-1:0] r_sq;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_exp;
    logic [WORD_BITS-1:0] r_out_data;
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] n_sq;
    logic [WORD_BITS-1:0] n_acc;
    logic [WORD_BITS-1:0] n_exp;
    logic [WORD_BITS-1:0] mm_a;
    logic [WORD_BITS-1:0] mm_result;
    logic                 mm_done;
    t_ctl                 ctl;
    t_status              status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power <= '0;
            r_mod   <= WORD_BITS'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_POWER:   r_power <= i_cfg_data;
                REG_MODULUS: r_mod   <= i_cfg_data;
                default:     r_power <= r_power;
            endcase
        end
    end

    always_comb begin
        status.in_valid = s_axis_tvalid;
        status.mm_done  = mm_done;
        status.exp_zero = (r_exp == '0);
        status.exp_even = !r_exp[0];
        status.out_busy = r_out_valid && !m_axis_tready;
    end

    mexp_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_status   (status),
        .o_ctl      (ctl),
        .o_in_ready (s_axis_tready)
    );

    always_comb begin
        case (ctl.mm_src)
            SRC_ONE: mm_a = WORD_BITS'(1);
            SRC_ACC: mm_a = r_acc;
            SRC_SQ:  mm_a = r_sq;
            default: mm_a = WORD_BITS'(1);
        endcase
    end

    mexp_modmul #(
        .WORD_BITS (WORD_BITS)
    ) u_modmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ctl.mm_start),
        .i_a      (mm_a),
        .i_b      (r_sq),
        .i_m      (r_mod),
        .o_done   (mm_done),
        .o_result (mm_result)
    );

    always_comb begin
        n_sq  = r_sq;
        n_acc = r_acc;
        n_exp = r_exp;
        if (ctl.load) begin
            n_sq  = s_axis_tdata[WORD_BITS-1:0];
            n_acc = WORD_BITS'(1);
            n_exp = r_power;
        end
        if (ctl.wr_sq) begin
            n_sq = mm_result;
        end
        if (ctl.wr_acc) begin
            n_acc = mm_result;
        end
        if (ctl.shift_exp) begin
            n_exp = r_exp >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq  <= n_sq;
        r_acc <= n_acc;
        r_exp <= n_exp;
        if (ctl.emit) begin
            r_out_data <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_BITS'(r_out_data);

    `MEXP_ASSERT_IMPL(a_no_overwrite, ctl.emit, !r_out_valid || m_axis_tready)
    `MEXP_ASSERT_IMPL(a_no_load_while_busy, ctl.load, !ctl.mm_start && !mm_done)

endmodule

`default_nettype wire

### design/mexp_modmul.sv
`default_nettype none
`include "assert_macros.svh"

module mexp_modmul #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [WORD_BITS-1:0] i_a,
    input  wire logic [WORD_BITS-1:0] i_b,
    input  wire logic [WORD_BITS-1:0] i_m,
    output logic                      o_done,
    output logic [WORD_BITS-1:0]      o_result
);

    import mexp_pkg::*;

    localparam int CNT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(WORD_BITS - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [WORD_BITS-1:0] r_a;
    logic [WORD_BITS-1:0] r_b;
    logic [WORD_BITS-1:0] r_m;
    logic [WORD_BITS-1:0] r_r;
    logic [WORD_BITS-1:0] n_dbl;
    logic [WORD_BITS-1:0] n_r;

    // A modulus of zero stands for 2^WORD_BITS: nothing is subtracted and the sum wraps.
    function automatic logic [WORD_BITS-1:0] add_mod(
        input logic [WORD_BITS-1:0] x,
        input logic [WORD_BITS-1:0] y,
        input logic [WORD_BITS-1:0] m
    );
        logic [WORD_BITS:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[WORD_BITS-1:0];
    endfunction

    always_comb begin
        n_dbl = add_mod(r_r, r_r, r_m);
        n_r   = r_b[WORD_BITS-1] ? add_mod(n_dbl, r_a, r_m) : n_dbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_m <= i_m;
            r_r <= '0;
        end else if (r_busy) begin
            r_r <= n_r;
            r_b <= r_b << 1;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_r;

    `MEXP_ASSERT_NEXT(a_done_after_last, r_busy && r_cnt == LAST && !i_start, r_done && !r_busy)
    `MEXP_ASSERT_IMPL(a_done_single, r_done, !$past(r_done))
    `MEXP_ASSERT_IMPL(a_cnt_bounded, r_busy, r_cnt <= LAST)

endmodule

`default_nettype wire

### design/mexp_sequencer.sv
`default_nettype none
`include "assert_macros.svh"

module mexp_sequencer (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mexp_pkg::t_status i_status,
    output mexp_pkg::t_ctl         o_ctl,
    output logic                   o_in_ready
);

    import mexp_pkg::*;

    logic [STEP_BITS-1:0] r_pc;
    logic [STEP_BITS-1:0] n_pc;
    t_uword               w;
    logic                 take;
    logic                 hold;

    assign w = PROGRAM[r_pc];

    always_comb begin
        unique case (w.cond)
            C_NEXT:     take = 1'b0;
            C_JUMP:     take = 1'b1;
            C_NO_INPUT: take = !i_status.in_valid;
            C_MM_BUSY:  take = !i_status.mm_done;
            C_EXP_ZERO: take = i_status.exp_zero;
            C_EXP_EVEN: take = i_status.exp_even;
            C_OUT_BUSY: take = i_status.out_busy;
            default:    take = 1'b0;
        endcase
    end

    // A step that jumps to itself is waiting, and its actions do not fire yet.
    assign hold = take && (w.target == r_pc);
    assign n_pc = take ? w.target : r_pc + 1'b1;

    always_comb begin
        o_ctl = w.ops;
        if (hold) begin
            o_ctl.mm_start  = 1'b0;
            o_ctl.wr_sq     = 1'b0;
            o_ctl.wr_acc    = 1'b0;
            o_ctl.shift_exp = 1'b0;
            o_ctl.load      = 1'b0;
            o_ctl.emit      = 1'b0;
        end
    end

    assign o_in_ready = w.ops.load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    `MEXP_ASSERT(a_pc_in_prog, r_pc < STEP_BITS'(PROG_LEN))

endmodule

`default_nettype wire

### tb/mexp_result_checker.sv
`default_nettype none

module mexp_result_checker #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  wire logic [WORD_BITS-1:0] i_in_data,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire logic [WORD_BITS-1:0] i_out_data,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [0:0]           i_cfg_index,
    input  wire logic [WORD_BITS-1:0] i_cfg_data,
    output int                        o_mismatches,
    output int                        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import mexp_pkg::*;

    logic [WORD_BITS-1:0] power_reg;
    logic [WORD_BITS-1:0] modulus_reg;
    logic [WORD_BITS-1:0] pending_powers[$];

    // A modulus of zero stands for 2^WORD_BITS, so the product simply wraps.
    function automatic logic [WORD_BITS-1:0] mul_mod(input logic [WORD_BITS-1:0] a,
                                                     input logic [WORD_BITS-1:0] b,
                                                     input logic [WORD_BITS-1:0] m);
        logic [2*WORD_BITS-1:0] wide_a;
        logic [2*WORD_BITS-1:0] wide_b;
        logic [2*WORD_BITS-1:0] wide_m;
        logic [2*WORD_BITS-1:0] prod;
        wide_a = {{WORD_BITS{1'b0}}, a};
        wide_b = {{WORD_BITS{1'b0}}, b};
        wide_m = {{WORD_BITS{1'b0}}, m};
        prod = wide_a * wide_b;
        if (m == '0) begin
            return prod[WORD_BITS-1:0];
        end
        prod = prod % wide_m;
        return prod[WORD_BITS-1:0];
    endfunction

    function automatic logic [WORD_BITS-1:0] mod_pow(input logic [WORD_BITS-1:0] base,
                                                     input logic [WORD_BITS-1:0] expo,
                                                     input logic [WORD_BITS-1:0] m);
        logic [WORD_BITS-1:0] square;
        logic [WORD_BITS-1:0] acc;
        logic [WORD_BITS-1:0] bits_left;
        square = base;
        if (m != '0) begin
            square = square % m;
        end
        acc = WORD_BITS'(1);
        bits_left = expo;
        while (bits_left != '0) begin
            if (bits_left[0]) begin
                acc = mul_mod(acc, square, m);
            end
            bits_left = bits_left >> 1;
            square = mul_mod(square, square, m);
        end
        return acc;
    endfunction

    always @(posedge i_clk) begin
        logic [WORD_BITS-1:0] want;
        if (!i_rst_n) begin
            power_reg <= '0;
            modulus_reg <= WORD_BITS'(1);
            pending_powers.delete();
            o_outstanding <= 0;
            o_mismatches <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_POWER) begin
                    power_reg <= i_cfg_data;
                end else if (i_cfg_index == REG_MODULUS) begin
                    modulus_reg <= i_cfg_data;
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_powers.push_back(mod_pow(i_in_data, power_reg, modulus_reg));
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_powers.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %h",
                             $time, i_out_data);
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = pending_powers.pop_front();
                    if (i_out_data !== want) begin
                        $display("%0t result_value mismatch: expected %h actual %h",
                                 $time, want, i_out_data);
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
            o_outstanding <= pending_powers.size();
        end
    end

endmodule

`default_nettype wire

### tb/modular_exponentiation_core_tb.sv
`default_nettype none

module modular_exponentiation_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mexp_pkg::*;

    localparam int WORD_BITS = 32;
    localparam int ITEM_TARGET = 270;
    localparam int STALL_LIMIT = 40000;
    localparam int DRAIN_CYCLES = 2500;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [WORD_BITS-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [WORD_BITS-1:0] m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [0:0]           i_cfg_index = REG_POWER;
    logic [WORD_BITS-1:0] i_cfg_data = '0;

    int  mismatches;
    int  outstanding;
    int  bases_sent = 0;
    int  quiet_cycles = 0;
    int  hold_left = 0;
    bit  steady = 1'b0;

    always #10 i_clk = ~i_clk;

    modular_exponentiation_core #(
        .WORD_BITS(WORD_BITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    mexp_result_checker #(
        .WORD_BITS(WORD_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    // Outside steady phases the receiver drops ready at random and now and then holds a long
    // stall so that a finished result sits in the output register while the next item is computed.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!steady && $urandom_range(3999) == 0) begin
            hold_left <= $urandom_range(50, 3000);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(99) >= 23);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int sender_gap();
        int n;
        n = 0;
        if (!steady) begin
            while ($urandom_range(99) < 23) begin
                n++;
            end
        end
        return n;
    endfunction

    task automatic push_base(input logic [WORD_BITS-1:0] base);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= base;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        bases_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [0:0] index, input logic [WORD_BITS-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
    endtask

    task automatic set_config(input logic [WORD_BITS-1:0] power,
                              input logic [WORD_BITS-1:0] modulus);
        wait_drained();
        if ($urandom_range(1) == 0) begin
            write_reg(REG_POWER, power);
            write_reg(REG_MODULUS, modulus);
        end else begin
            write_reg(REG_MODULUS, modulus);
            write_reg(REG_POWER, power);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [WORD_BITS-1:0] power;
        logic [WORD_BITS-1:0] modulus;
        logic [WORD_BITS-1:0] base;
        int bit_len;
        int phase;
        int phase_len;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: zero power with modulus one still gives one.
        push_base('0);
        push_base('1);

        set_config('0, 32'hFFFF_FFFF);
        push_base(32'd5);

        set_config(32'd1, 32'd1);
        push_base('1);
        push_base(32'd7);

        set_config('1, 32'hFFFF_FFFF);
        push_base('1);
        push_base(32'hFFFF_FFFE);
        push_base(32'd2);

        // A zero modulus means plain wrapping arithmetic.
        set_config('1, '0);
        push_base(32'd3);
        push_base('1);

        set_config(32'd2, '0);
        push_base(32'h0001_0000);

        set_config(32'd65537, 32'hFFFF_FFFB);
        push_base('0);
        push_base(32'd1);
        push_base(32'hFFFF_FFFA);
        push_base(32'h8000_0000);
        push_base(32'hFFFF_FFFB);

        set_config(32'h8000_0000, 32'd2);
        push_base(32'd3);
        push_base(32'd4);

        set_config('0, '0);
        push_base(32'h1234_5678);

        phase = 0;
        while (bases_sent < ITEM_TARGET) begin
            case ($urandom_range(9))
                0: modulus = '0;
                1: modulus = 32'd1;
                2: modulus = 32'hFFFF_FFFF;
                3, 4: modulus = $urandom_range(2, 255);
                5, 6: modulus = $urandom;
                default: modulus = {1'b1, 31'($urandom)};
            endcase
            case ($urandom_range(9))
                0: power = '0;
                1: power = {1'b1, 31'($urandom)};
                default: begin
                    bit_len = $urandom_range(1, 12);
                    power = ($urandom & ((32'd1 << bit_len) - 1)) | (32'd1 << (bit_len - 1));
                end
            endcase
            set_config(power, modulus);
            steady = (phase >= 4 && phase < 7);
            phase_len = $urandom_range(4, 20);
            for (int k = 0; k < phase_len; k++) begin
                case ($urandom_range(9))
                    0: base = '0;
                    1: base = '1;
                    2: base = modulus - 1;
                    3: base = modulus;
                    4: base = modulus + 1;
                    default: base = $urandom;
                endcase
                push_base(base);
            end
            phase++;
        end

        wait_drained();
        steady = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

### modular_exponentiation_core.f
+incdir+design
design/mexp_pkg.sv
design/mexp_modmul.sv
design/mexp_sequencer.sv
design/modular_exponentiation_core.sv
tb/mexp_result_checker.sv
tb/modular_exponentiation_core_tb.sv
